// ----- rtl/bcd_clock_with_set_and_scan_defines.svh -----
// Assertion macros used by the checker file of the BCD clock.
`ifndef BCD_CLOCK_WITH_SET_AND_SCAN_DEFINES_SVH
`define BCD_CLOCK_WITH_SET_AND_SCAN_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low
`define BCS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low
`define BCS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/bcs_pkg.sv -----
package bcs_pkg;

    // Event kinds carried on the input tuser
    typedef enum logic [1:0] {
        FUNC_TICK   = 2'd0,
        FUNC_MODE   = 2'd1,
        FUNC_ADJUST = 2'd2,
        FUNC_SCAN   = 2'd3
    } func_t;

    typedef struct packed {
        func_t func;
        logic  hour_key_down;
        logic  minute_key_down;
        logic  shift_key_down;
    } event_t;

    // BCD time, each digit only as wide as its range
    typedef struct packed {
        logic [1:0] h1;
        logic [3:0] h0;
        logic [2:0] m1;
        logic [3:0] m0;
        logic [2:0] s1;
        logic [3:0] s0;
    } time_t;

    // Clock status handed from the core to the output stage
    typedef struct packed {
        time_t      tm;
        logic       adjust;
        logic [2:0] scan_pos;
    } clock_state_t;

    localparam int IN_TDATA_W  = 8;
    localparam int IN_TUSER_W  = 2;
    localparam int OUT_TDATA_W = 40;
    localparam int TPS_W       = 8;

    localparam logic [TPS_W-1:0] TPS_RESET = 8'd20;

    localparam logic [7:0] SEG_DASH  = 8'hbf;
    localparam logic [7:0] SEG_BLANK = 8'hff;

endpackage

// ----- rtl/bcs_clock_core.sv -----
module bcs_clock_core
    import bcs_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [TPS_W-1:0]   cfg_wdata,
    input  logic               evt_fire,
    input  event_t             evt,
    output clock_state_t       state_next
);

    logic [TPS_W-1:0] tps_reg;
    logic [TPS_W-1:0] presc_reg;
    logic [TPS_W-1:0] presc_next;
    clock_state_t     state_reg;
    logic [TPS_W:0]   presc_inc;
    logic             sec_due;
    time_t            cur;
    time_t            tick_time;
    time_t            adj_time;

    assign cur       = state_reg.tm;
    assign presc_inc = {1'b0, presc_reg} + {{TPS_W{1'b0}}, 1'b1};
    assign sec_due   = (presc_inc >= {1'b0, tps_reg});

    // Add one second with BCD carries, wrap at end of day
    always_comb
    begin
        tick_time = cur;
        if (cur.s0 != 4'd9)
        begin
            tick_time.s0 = cur.s0 + 4'd1;
        end
        else
        begin
            tick_time.s0 = 4'd0;
            if (cur.s1 != 3'd5)
            begin
                tick_time.s1 = cur.s1 + 3'd1;
            end
            else
            begin
                tick_time.s1 = 3'd0;
                if (cur.m0 != 4'd9)
                begin
                    tick_time.m0 = cur.m0 + 4'd1;
                end
                else
                begin
                    tick_time.m0 = 4'd0;
                    if (cur.m1 != 3'd5)
                    begin
                        tick_time.m1 = cur.m1 + 3'd1;
                    end
                    else
                    begin
                        tick_time.m1 = 3'd0;
                        if (cur.h1 == 2'd2 && cur.h0 == 4'd3)
                        begin
                            tick_time.h1 = 2'd0;
                            tick_time.h0 = 4'd0;
                        end
                        else if (cur.h0 < 4'd9)
                        begin
                            tick_time.h0 = cur.h0 + 4'd1;
                        end
                        else
                        begin
                            tick_time.h0 = 4'd0;
                            tick_time.h1 = cur.h1 + 2'd1;
                        end
                    end
                end
            end
        end
    end

    // Adjust step: clear seconds, step hours and/or minutes with wrap
    always_comb
    begin
        adj_time    = cur;
        adj_time.s0 = 4'd0;
        adj_time.s1 = 3'd0;
        if (evt.hour_key_down)
        begin
            if (!evt.shift_key_down)
            begin
                if (cur.h1 == 2'd2 && cur.h0 == 4'd3)
                begin
                    adj_time.h1 = 2'd0;
                    adj_time.h0 = 4'd0;
                end
                else if (cur.h0 != 4'd9)
                begin
                    adj_time.h0 = cur.h0 + 4'd1;
                end
                else
                begin
                    adj_time.h0 = 4'd0;
                    adj_time.h1 = cur.h1 + 2'd1;
                end
            end
            else
            begin
                if (cur.h1 == 2'd0 && cur.h0 == 4'd0)
                begin
                    adj_time.h1 = 2'd2;
                    adj_time.h0 = 4'd3;
                end
                else if (cur.h0 != 4'd0)
                begin
                    adj_time.h0 = cur.h0 - 4'd1;
                end
                else
                begin
                    adj_time.h0 = 4'd9;
                    adj_time.h1 = cur.h1 - 2'd1;
                end
            end
        end
        if (evt.minute_key_down)
        begin
            if (!evt.shift_key_down)
            begin
                if (cur.m1 == 3'd5 && cur.m0 == 4'd9)
                begin
                    adj_time.m1 = 3'd0;
                    adj_time.m0 = 4'd0;
                end
                else if (cur.m0 != 4'd9)
                begin
                    adj_time.m0 = cur.m0 + 4'd1;
                end
                else
                begin
                    adj_time.m0 = 4'd0;
                    adj_time.m1 = cur.m1 + 3'd1;
                end
            end
            else
            begin
                if (cur.m1 == 3'd0 && cur.m0 == 4'd0)
                begin
                    adj_time.m1 = 3'd5;
                    adj_time.m0 = 4'd9;
                end
                else if (cur.m0 != 4'd0)
                begin
                    adj_time.m0 = cur.m0 - 4'd1;
                end
                else
                begin
                    adj_time.m0 = 4'd9;
                    adj_time.m1 = cur.m1 - 3'd1;
                end
            end
        end
    end

    // Decode the event into the next clock state
    always_comb
    begin
        state_next = state_reg;
        presc_next = presc_reg;
        unique case (evt.func)
            FUNC_TICK:
            begin
                if (!state_reg.adjust)
                begin
                    if (sec_due)
                    begin
                        presc_next    = '0;
                        state_next.tm = tick_time;
                    end
                    else
                    begin
                        presc_next = presc_inc[TPS_W-1:0];
                    end
                end
            end
            FUNC_MODE:
            begin
                state_next.adjust = !state_reg.adjust;
            end
            FUNC_ADJUST:
            begin
                if (state_reg.adjust)
                begin
                    state_next.tm = adj_time;
                end
            end
            FUNC_SCAN:
            begin
                state_next.scan_pos = state_reg.scan_pos + 3'd1;
            end
            default:
            begin
                state_next = state_reg;
            end
        endcase
    end

    // Commit the event when it moves into the result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '0;
            presc_reg <= '0;
        end
        else if (evt_fire)
        begin
            state_reg <= state_next;
            presc_reg <= presc_next;
        end
    end

    // Hold the ticks-per-second setting
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tps_reg <= TPS_RESET;
        end
        else if (cfg_we)
        begin
            tps_reg <= cfg_wdata;
        end
    end

endmodule

// ----- rtl/bcs_out_stage.sv -----
module bcs_out_stage
    import bcs_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   load,
    input  clock_state_t           state_next,
    input  logic                   m_tready,
    output logic                   m_tvalid,
    output logic [OUT_TDATA_W-1:0] m_tdata
);

    logic                   m_tvalid_reg;
    logic [OUT_TDATA_W-1:0] m_tdata_reg;
    logic [OUT_TDATA_W-1:0] m_tdata_next;
    logic [3:0]             shown_digit;
    logic                   shown_dash;
    logic [7:0]             seg;
    logic [7:0]             sel_n;
    logic                   midnight;
    time_t                  tm;

    function automatic logic [7:0] seg_of(input logic [3:0] d);
        logic [7:0] s;
        case (d)
            4'd0:    s = 8'hc0;
            4'd1:    s = 8'hf9;
            4'd2:    s = 8'ha4;
            4'd3:    s = 8'hb0;
            4'd4:    s = 8'h99;
            4'd5:    s = 8'h92;
            4'd6:    s = 8'h82;
            4'd7:    s = 8'hf8;
            4'd8:    s = 8'h80;
            4'd9:    s = 8'h98;
            default: s = SEG_BLANK;
        endcase
        return s;
    endfunction

    assign tm = state_next.tm;

    // Pick the digit at the scan position: S0 S1 - M0 M1 - H0 H1
    always_comb
    begin
        shown_dash  = 1'b0;
        shown_digit = 4'd0;
        unique case (state_next.scan_pos)
            3'd0:    shown_digit = tm.s0;
            3'd1:    shown_digit = {1'b0, tm.s1};
            3'd3:    shown_digit = tm.m0;
            3'd4:    shown_digit = {1'b0, tm.m1};
            3'd6:    shown_digit = tm.h0;
            3'd7:    shown_digit = {2'b00, tm.h1};
            default: shown_dash  = 1'b1;
        endcase
    end

    assign seg      = shown_dash ? SEG_DASH : seg_of(shown_digit);
    assign sel_n    = ~(8'd1 << state_next.scan_pos);
    assign midnight = !state_next.adjust && (tm == '0);

    // Pack the result, digit_select in the low bits
    assign m_tdata_next = {2'b00, midnight, state_next.adjust,
                           tm.s0, tm.s1, tm.m0, tm.m1, tm.h0, tm.h1, seg, sel_n};

    // Hold the result until the downstream side takes it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (load)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            m_tdata_reg <= m_tdata_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

// ----- rtl/bcd_clock_with_set_and_scan.sv -----
// Channel  Ports                        Contents (low bit up)
// -------  ---------------------------  --------------------------------------------
// in       s_tvalid s_tready s_tdata    tdata: hour_key_down, minute_key_down,
//          s_tuser                      shift_key_down; tuser: func
// out      m_tvalid m_tready m_tdata    digit_select, segment_code, hours_tens,
//                                       hours_units, minutes_tens, minutes_units,
//                                       seconds_tens, seconds_units, adjust_active,
//                                       at_midnight
// config   cfg_we cfg_wdata             ticks_per_second
//
// One event per cycle while the output drains; a result passes the input register,
// then the result register, after the combinational state update.
// rst_n clears time to 00:00:00, counting mode, scan position 0, prescaler 0,
// ticks_per_second to 20. A stalled output holds its result; the input
// register keeps taking transfers as long as the result register can drain.
module bcd_clock_with_set_and_scan
    import bcs_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [TPS_W-1:0]       cfg_wdata,    // ticks_per_second
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,      // hour_key_down, minute_key_down, shift_key_down
    input  logic [IN_TUSER_W-1:0]  s_tuser,      // func
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata       // digit_select .. at_midnight, see table
);

    logic         in_valid_reg;
    event_t       in_evt_reg;
    event_t       in_evt;
    logic         advance;
    logic         fire;
    logic         accept;
    clock_state_t state_next;

    // Move on when the result register is empty or being drained
    assign advance  = !m_tvalid || m_tready;
    assign fire     = in_valid_reg && advance;
    assign s_tready = !in_valid_reg || advance;
    assign accept   = s_tvalid && s_tready;

    assign in_evt.func            = func_t'(s_tuser);
    assign in_evt.hour_key_down   = s_tdata[0];
    assign in_evt.minute_key_down = s_tdata[1];
    assign in_evt.shift_key_down  = s_tdata[2];

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (fire)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_evt_reg <= in_evt;
        end
    end

    bcs_clock_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .evt_fire   (fire),
        .evt        (in_evt_reg),
        .state_next (state_next)
    );

    bcs_out_stage u_out (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (fire),
        .state_next (state_next),
        .m_tready   (m_tready),
        .m_tvalid   (m_tvalid),
        .m_tdata    (m_tdata)
    );

endmodule

// ----- rtl/bcs_checker.sv -----
`include "bcd_clock_with_set_and_scan_defines.svh"

module bcs_checker
    import bcs_pkg::*;
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   m_tvalid,
    input logic                   m_tready,
    input logic [OUT_TDATA_W-1:0] m_tdata
);

    // Stalled result stays put
    `BCS_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "stalled result changed")

    // Exactly one digit select is low
    `BCS_ASSERT_NOW(a_one_digit, m_tvalid, $onehot(~m_tdata[7:0]), "digit select not one-hot low")

    // Separator positions show a dash
    `BCS_ASSERT_NOW(a_dash, m_tvalid && (m_tdata[7:0] == 8'hfb || m_tdata[7:0] == 8'hdf), m_tdata[15:8] == 8'hbf, "separator without dash")

    // Midnight flag only with all digits zero in counting mode
    `BCS_ASSERT_NOW(a_midnight, m_tvalid && m_tdata[37], m_tdata[36:16] == 21'd0, "midnight flag with nonzero time")

    // Hours never pass 23
    `BCS_ASSERT_NOW(a_hours, m_tvalid && m_tdata[17:16] == 2'd2, m_tdata[21:18] <= 4'd3, "hours above 23")

endmodule

bind bcd_clock_with_set_and_scan bcs_checker u_bcs_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ----- test/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top;
    import bcs_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int PRINT_LIMIT = 40;

    // Result word as it travels on m_tdata, highest field first
    typedef struct packed {
        logic [1:0] pad;
        logic       at_midnight;
        logic       adjust_active;
        logic [3:0] seconds_units;
        logic [2:0] seconds_tens;
        logic [3:0] minutes_units;
        logic [2:0] minutes_tens;
        logic [3:0] hours_units;
        logic [1:0] hours_tens;
        logic [7:0] segment_code;
        logic [7:0] digit_select;
    } readout_t;

    typedef struct {
        event_t   ev;
        bit       typed;
        readout_t want;
    } directed_row_t;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   cfg_we;
    logic [TPS_W-1:0]       cfg_wdata;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata;
    logic [IN_TUSER_W-1:0]  s_tuser;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;

    // Shadow copy of the clock
    time_t      now_time;
    logic [7:0] prescale;
    bit         adj_mode;
    logic [2:0] scan_pos;
    logic [7:0] tps_cfg;

    readout_t      pending_readouts[$];
    directed_row_t directed_rows[$];

    bit         idle_on = 1'b1;
    int         cycle_count = 0;
    int         events_sent = 0;
    int         events_counted = 0;
    int         readouts_checked = 0;
    int         mismatches = 0;
    int         midnight_wraps = 0;
    logic [7:0] rand_tps;

    bcd_clock_with_set_and_scan dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    // Free-running clock, 10 ns period
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic bit rand_bit();
        return 1'($urandom_range(0, 1));
    endfunction

    function automatic logic [7:0] digit_code(logic [3:0] d);
        case (d)
            4'd0:    return 8'hc0;
            4'd1:    return 8'hf9;
            4'd2:    return 8'ha4;
            4'd3:    return 8'hb0;
            4'd4:    return 8'h99;
            4'd5:    return 8'h92;
            4'd6:    return 8'h82;
            4'd7:    return 8'hf8;
            4'd8:    return 8'h80;
            4'd9:    return 8'h98;
            default: return SEG_BLANK;
        endcase
    endfunction

    // Step a two-digit BCD field by one, wrapping between 00 and the top value
    function automatic logic [7:0] step_pair(logic [3:0] tens, logic [3:0] units,
                                             logic [3:0] top_t, logic [3:0] top_u,
                                             bit down);
        if (!down)
        begin
            if (tens == top_t && units == top_u)
                return 8'h00;
            if (units != 4'd9)
                return {tens, units + 4'd1};
            return {tens + 4'd1, 4'd0};
        end
        if (tens == 4'd0 && units == 4'd0)
            return {top_t, top_u};
        if (units != 4'd0)
            return {tens, units - 4'd1};
        return {tens - 4'd1, 4'd9};
    endfunction

    // Build a readout from BCD-coded time values
    function automatic readout_t make_readout(logic [7:0] sel, logic [7:0] seg,
                                              logic [7:0] hh, logic [7:0] mm,
                                              logic [7:0] ss, bit adj, bit mid);
        readout_t r;
        r = '0;
        r.digit_select  = sel;
        r.segment_code  = seg;
        r.hours_tens    = hh[5:4];
        r.hours_units   = hh[3:0];
        r.minutes_tens  = mm[6:4];
        r.minutes_units = mm[3:0];
        r.seconds_tens  = ss[6:4];
        r.seconds_units = ss[3:0];
        r.adjust_active = adj;
        r.at_midnight   = mid;
        return r;
    endfunction

    // Add one second with BCD carries, wrapping 23:59:59 to midnight
    task automatic add_second();
        if (now_time.s0 < 4'd9)
            now_time.s0 = now_time.s0 + 4'd1;
        else
        begin
            now_time.s0 = 4'd0;
            if (now_time.s1 < 3'd5)
                now_time.s1 = now_time.s1 + 3'd1;
            else
            begin
                now_time.s1 = 3'd0;
                if (now_time.m0 < 4'd9)
                    now_time.m0 = now_time.m0 + 4'd1;
                else
                begin
                    now_time.m0 = 4'd0;
                    if (now_time.m1 < 3'd5)
                        now_time.m1 = now_time.m1 + 3'd1;
                    else
                    begin
                        now_time.m1 = 3'd0;
                        if (now_time.h1 == 2'd2 && now_time.h0 == 4'd3)
                        begin
                            now_time.h1 = 2'd0;
                            now_time.h0 = 4'd0;
                            midnight_wraps++;
                        end
                        else if (now_time.h0 < 4'd9)
                            now_time.h0 = now_time.h0 + 4'd1;
                        else
                        begin
                            now_time.h0 = 4'd0;
                            now_time.h1 = now_time.h1 + 2'd1;
                        end
                    end
                end
            end
        end
    endtask

    // Apply one event to the shadow clock and form the readout it produces
    task automatic advance_clock(input event_t ev, output readout_t r);
        int         nxt;
        logic [7:0] pair;
        logic [7:0] seg;
        case (ev.func)
            FUNC_TICK:
            begin
                if (!adj_mode)
                begin
                    nxt = int'(prescale) + 1;
                    if (nxt >= int'(tps_cfg))
                    begin
                        prescale = 8'd0;
                        add_second();
                    end
                    else
                        prescale = 8'(nxt);
                end
            end
            FUNC_MODE:
                adj_mode = !adj_mode;
            FUNC_ADJUST:
            begin
                if (adj_mode)
                begin
                    now_time.s0 = 4'd0;
                    now_time.s1 = 3'd0;
                    if (ev.hour_key_down)
                    begin
                        pair = step_pair({2'b00, now_time.h1}, now_time.h0, 4'd2, 4'd3,
                                         ev.shift_key_down);
                        now_time.h1 = pair[5:4];
                        now_time.h0 = pair[3:0];
                    end
                    if (ev.minute_key_down)
                    begin
                        pair = step_pair({1'b0, now_time.m1}, now_time.m0, 4'd5, 4'd9,
                                         ev.shift_key_down);
                        now_time.m1 = pair[6:4];
                        now_time.m0 = pair[3:0];
                    end
                end
            end
            default:
                scan_pos = scan_pos + 3'd1;
        endcase

        // Look up the digit under the scan pointer; separators show a dash
        case (scan_pos)
            3'd0:    seg = digit_code(now_time.s0);
            3'd1:    seg = digit_code({1'b0, now_time.s1});
            3'd3:    seg = digit_code(now_time.m0);
            3'd4:    seg = digit_code({1'b0, now_time.m1});
            3'd6:    seg = digit_code(now_time.h0);
            3'd7:    seg = digit_code({2'b00, now_time.h1});
            default: seg = SEG_DASH;
        endcase

        r = '0;
        r.digit_select  = ~(8'd1 << scan_pos);
        r.segment_code  = seg;
        r.hours_tens    = now_time.h1;
        r.hours_units   = now_time.h0;
        r.minutes_tens  = now_time.m1;
        r.minutes_units = now_time.m0;
        r.seconds_tens  = now_time.s1;
        r.seconds_units = now_time.s0;
        r.adjust_active = adj_mode;
        r.at_midnight   = !adj_mode && (now_time == '0);
    endtask

    task automatic report_mismatch(input string msg);
        mismatches++;
        if (mismatches <= PRINT_LIMIT)
            $display("%s", msg);
    endtask

    task automatic check_field(input string name, input logic [7:0] got,
                               input logic [7:0] want);
        if (got !== want)
            report_mismatch($sformatf("readout %0d: %s is 0x%0h, expected 0x%0h",
                                      readouts_checked, name, got, want));
    endtask

    task automatic check_readout(input readout_t got, input readout_t want);
        check_field("digit_select",  got.digit_select,  want.digit_select);
        check_field("segment_code",  got.segment_code,  want.segment_code);
        check_field("hours_tens",    8'(got.hours_tens),    8'(want.hours_tens));
        check_field("hours_units",   8'(got.hours_units),   8'(want.hours_units));
        check_field("minutes_tens",  8'(got.minutes_tens),  8'(want.minutes_tens));
        check_field("minutes_units", 8'(got.minutes_units), 8'(want.minutes_units));
        check_field("seconds_tens",  8'(got.seconds_tens),  8'(want.seconds_tens));
        check_field("seconds_units", 8'(got.seconds_units), 8'(want.seconds_units));
        check_field("adjust_active", 8'(got.adjust_active), 8'(want.adjust_active));
        check_field("at_midnight",   8'(got.at_midnight),   8'(want.at_midnight));
        readouts_checked++;
    endtask

    // Push one event through the input channel and record what it should yield
    task automatic push_event(input event_t ev, input bit typed, input readout_t want);
        readout_t predicted;
        bit       ignored;
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            s_tvalid = 1'b0;
            repeat ($urandom_range(1, 10)) @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tuser  = ev.func;
        s_tdata  = {5'b0, ev.shift_key_down, ev.minute_key_down, ev.hour_key_down};
        do
            @(posedge clk);
        while (!s_tready);

        // Transfer done at this edge
        ignored = (ev.func == FUNC_TICK && adj_mode) || (ev.func == FUNC_ADJUST && !adj_mode);
        advance_clock(ev, predicted);
        pending_readouts.push_back(typed ? want : predicted);
        events_sent++;
        if (!ignored)
            events_counted++;
        @(negedge clk);
    endtask

    task automatic send(input func_t f, input bit hk, input bit mk, input bit sk);
        event_t ev;
        ev.func            = f;
        ev.hour_key_down   = hk;
        ev.minute_key_down = mk;
        ev.shift_key_down  = sk;
        push_event(ev, 1'b0, '0);
    endtask

    task automatic add_row(input func_t f, input bit hk, input bit mk, input bit sk,
                           input bit typed, input readout_t want);
        directed_row_t row;
        row.ev.func            = f;
        row.ev.hour_key_down   = hk;
        row.ev.minute_key_down = mk;
        row.ev.shift_key_down  = sk;
        row.typed              = typed;
        row.want               = want;
        directed_rows.push_back(row);
    endtask

    // Write ticks_per_second once every result has drained
    task automatic set_tps(input logic [7:0] value);
        s_tvalid = 1'b0;
        while (pending_readouts.size() != 0)
            @(negedge clk);
        cfg_we    = 1'b1;
        cfg_wdata = value;
        @(negedge clk);
        cfg_we    = 1'b0;
        tps_cfg   = value;
    endtask

    // Random traffic built from setting sequences, tick runs, scans and noise
    task automatic run_phase(input int target);
        int start_count;
        int steps;
        int hrs;
        int mins;
        int up_steps;
        int down_steps;
        int i;
        bit go_down;
        start_count = events_counted;
        while (events_counted - start_count < target)
        begin
            case ($urandom_range(0, 15))
                0:
                begin
                    // Walk the time to 23:59 the short way, then tick; at up to 3 ticks per second it rolls over
                    if (!adj_mode)
                        send(FUNC_MODE, rand_bit(), rand_bit(), rand_bit());
                    hrs        = int'(now_time.h1) * 10 + int'(now_time.h0);
                    up_steps   = (23 - hrs + 24) % 24;
                    down_steps = (hrs + 1) % 24;
                    go_down    = down_steps < up_steps;
                    steps      = go_down ? down_steps : up_steps;
                    for (i = 0; i < steps; i++)
                        send(FUNC_ADJUST, 1'b1, 1'b0, go_down);
                    mins       = int'(now_time.m1) * 10 + int'(now_time.m0);
                    up_steps   = (59 - mins + 60) % 60;
                    down_steps = (mins + 1) % 60;
                    go_down    = down_steps < up_steps;
                    steps      = go_down ? down_steps : up_steps;
                    for (i = 0; i < steps; i++)
                        send(FUNC_ADJUST, 1'b0, 1'b1, go_down);
                    send(FUNC_MODE, rand_bit(), rand_bit(), rand_bit());
                    if (tps_cfg <= 8'd3)
                        steps = 61 * ((tps_cfg == 8'd0) ? 1 : int'(tps_cfg));
                    else
                        steps = int'($urandom_range(1, 60));
                    for (i = 0; i < steps; i++)
                        send(FUNC_TICK, rand_bit(), rand_bit(), rand_bit());
                end
                1, 2:
                begin
                    // Setting sequence with random keys, now and then broken up
                    if (!adj_mode)
                        send(FUNC_MODE, rand_bit(), rand_bit(), rand_bit());
                    steps = int'($urandom_range(1, 8));
                    for (i = 0; i < steps; i++)
                    begin
                        if ($urandom_range(0, 5) == 0)
                            send(rand_bit() ? FUNC_TICK : FUNC_SCAN,
                                 rand_bit(), rand_bit(), rand_bit());
                        else
                            send(FUNC_ADJUST, rand_bit(), rand_bit(), rand_bit());
                    end
                    if ($urandom_range(0, 7) != 0)
                        send(FUNC_MODE, rand_bit(), rand_bit(), rand_bit());
                end
                3, 4, 5, 6, 7, 8, 9:
                begin
                    // Run of base ticks with the odd scan
                    steps = int'($urandom_range(1, 60));
                    for (i = 0; i < steps; i++)
                        send(($urandom_range(0, 9) == 0) ? FUNC_SCAN : FUNC_TICK,
                             rand_bit(), rand_bit(), rand_bit());
                end
                10, 11:
                begin
                    steps = int'($urandom_range(1, 9));
                    for (i = 0; i < steps; i++)
                        send(FUNC_SCAN, rand_bit(), rand_bit(), rand_bit());
                end
                default:
                    send(func_t'(2'($urandom_range(0, 3))), rand_bit(), rand_bit(), rand_bit());
            endcase
        end
    endtask

    // Stall the result channel in random bursts
    initial
    begin
        m_tready = 1'b1;
        forever
        begin
            @(negedge clk);
            if (idle_on && $urandom_range(0, 7) == 0)
            begin
                m_tready = 1'b0;
                repeat ($urandom_range(1, 10)) @(negedge clk);
                m_tready = 1'b1;
            end
        end
    end

    // Check each result transfer against the oldest expectation; bound the run
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("run stopped after %0d cycles, %0d readouts still expected",
                     cycle_count, pending_readouts.size());
            $display("bcd_clock_with_set_and_scan: mismatch");
            $finish;
        end
        else if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_readouts.size() == 0)
                report_mismatch($sformatf("readout with nothing expected: 0x%0h", m_tdata));
            else
                check_readout(readout_t'(m_tdata), pending_readouts.pop_front());
        end
    end

    initial
    begin
        // Drive every input to a known value and hold reset
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_wdata = 8'd0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = FUNC_TICK;
        now_time  = '0;
        prescale  = 8'd0;
        adj_mode  = 1'b0;
        scan_pos  = 3'd0;
        tps_cfg   = TPS_RESET;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed events from reset; typed rows are read straight off the spec
        add_row(FUNC_TICK,   0, 0, 0, 1, make_readout(8'hfe, 8'hc0, 8'h00, 8'h00, 8'h00, 0, 1));
        add_row(FUNC_SCAN,   0, 0, 0, 1, make_readout(8'hfd, 8'hc0, 8'h00, 8'h00, 8'h00, 0, 1));
        add_row(FUNC_SCAN,   0, 0, 0, 1, make_readout(8'hfb, 8'hbf, 8'h00, 8'h00, 8'h00, 0, 1));
        add_row(FUNC_MODE,   0, 0, 0, 1, make_readout(8'hfb, 8'hbf, 8'h00, 8'h00, 8'h00, 1, 0));
        add_row(FUNC_TICK,   0, 0, 0, 0, '0);
        add_row(FUNC_ADJUST, 1, 0, 1, 1, make_readout(8'hfb, 8'hbf, 8'h23, 8'h00, 8'h00, 1, 0));
        add_row(FUNC_ADJUST, 0, 1, 1, 1, make_readout(8'hfb, 8'hbf, 8'h23, 8'h59, 8'h00, 1, 0));
        add_row(FUNC_ADJUST, 1, 1, 0, 1, make_readout(8'hfb, 8'hbf, 8'h00, 8'h00, 8'h00, 1, 0));
        add_row(FUNC_ADJUST, 1, 1, 1, 0, '0);
        add_row(FUNC_ADJUST, 0, 0, 0, 0, '0);
        add_row(FUNC_ADJUST, 1, 0, 0, 0, '0);
        add_row(FUNC_MODE,   1, 1, 1, 0, '0);
        add_row(FUNC_ADJUST, 1, 1, 0, 0, '0);
        add_row(FUNC_TICK,   1, 1, 1, 0, '0);
        add_row(FUNC_SCAN,   1, 0, 0, 0, '0);
        add_row(FUNC_SCAN,   0, 1, 0, 0, '0);
        add_row(FUNC_SCAN,   0, 0, 1, 0, '0);
        add_row(FUNC_SCAN,   1, 1, 1, 0, '0);
        add_row(FUNC_SCAN,   0, 0, 0, 0, '0);
        add_row(FUNC_SCAN,   1, 0, 1, 0, '0);
        add_row(FUNC_TICK,   0, 0, 0, 0, '0);
        add_row(FUNC_MODE,   0, 0, 0, 0, '0);
        add_row(FUNC_MODE,   0, 0, 0, 0, '0);
        foreach (directed_rows[i])
            push_event(directed_rows[i].ev, directed_rows[i].typed, directed_rows[i].want);

        // Random traffic across several tick rates; 3 right after 255 lowers the rate
        rand_tps = 8'($urandom_range(4, 254));
        set_tps(8'd255);
        run_phase(170);
        set_tps(8'd3);
        run_phase(170);
        set_tps(8'd0);
        run_phase(170);
        set_tps(8'd1);
        run_phase(170);
        set_tps(rand_tps);
        run_phase(170);
        set_tps(8'd2);
        run_phase(170);

        // Close at full rate with no idling on either side
        idle_on = 1'b0;
        set_tps(8'd1);
        run_phase(170);
        s_tvalid = 1'b0;

        // Drain, then keep watching for anything stray
        while (pending_readouts.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        $display("covered %0d events (%0d not ignored), %0d readouts compared, %0d rollovers",
                 events_sent, events_counted, readouts_checked, midnight_wraps);
        $display("tick rates 20 255 3 0 1 %0d 2 1, with random idling on both channels",
                 rand_tps);
        if (mismatches == 0)
            $display("bcd_clock_with_set_and_scan: match");
        else
            $display("bcd_clock_with_set_and_scan: mismatch");
        $finish;
    end

endmodule
